[hdl/hkt_pkg.sv]
// ----------------------------------------------------------------------------
// hkt_pkg
// shared types, constants and a digit lookup function for the keyboard translator
// ----------------------------------------------------------------------------
package hkt_pkg;

  localparam int KEY_SLOTS    = 6;
  localparam int CNT_W        = 3;
  localparam int REPORT_BYTES = 8;

  localparam logic [7:0] CAPS_CODE  = 8'h39;
  localparam logic [7:0] SHIFT_MASK = 8'h22;
  localparam logic [7:0] UNSUP_MASK = 8'hDD;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_ROLLOVER = 2'd2;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] val;
    logic       sh;
    logic       rep;
  } item_t;

  typedef struct packed {
    logic       is_new;
    logic       is_caps;
    logic       ok;
    logic       kind;
    logic [7:0] val;
    logic       sh;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] emitted;
    logic [CNT_W-1:0] dropped;
    logic [31:0]      total;
  } summ_t;

  function automatic logic [7:0] digit_char(input logic [3:0] idx, input logic shift);
    logic [7:0] c;
    c = 8'h30;
    if (!shift) begin
      unique case (idx)
        4'd0: c = "1";
        4'd1: c = "2";
        4'd2: c = "3";
        4'd3: c = "4";
        4'd4: c = "5";
        4'd5: c = "6";
        4'd6: c = "7";
        4'd7: c = "8";
        4'd8: c = "9";
        default: c = "0";
      endcase
    end else begin
      unique case (idx)
        4'd0: c = "!";
        4'd1: c = "@";
        4'd2: c = "#";
        4'd3: c = "$";
        4'd4: c = "%";
        4'd5: c = "^";
        4'd6: c = "&";
        4'd7: c = "*";
        4'd8: c = "(";
        default: c = ")";
      endcase
    end
    return c;
  endfunction

endpackage

[hdl/hkt_lane.sv]
// ----------------------------------------------------------------------------
// hkt_lane
// one key slot: new-key detection and usage code translation
// ----------------------------------------------------------------------------
module hkt_lane (
  input  logic [7:0]                           code,
  input  logic [7:0]                           mods,
  input  logic                                 caps_in,
  input  logic [hkt_pkg::KEY_SLOTS-1:0][7:0]   prev_keys,
  output hkt_pkg::lane_res_t                   res
);
  import hkt_pkg::*;

  logic       shift, unsup, upper, seen, key_v, txt_v, tsh;
  logic [7:0] key, txt, off;
  logic [7:0] dig;

  always_comb begin
    shift = |(mods & SHIFT_MASK);
    unsup = |(mods & UNSUP_MASK);
    upper = shift ^ caps_in;
    seen  = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (prev_keys[i] == code) seen = 1'b1;
    end
    key_v = 1'b0;
    txt_v = 1'b0;
    key   = 8'd0;
    txt   = 8'd0;
    tsh   = 1'b0;
    off   = code - 8'h04;
    dig   = code - 8'h1E;
    if (code >= 8'h04 && code <= 8'h1D) begin
      txt_v = 1'b1;
      txt   = (upper ? 8'h41 : 8'h61) + off;
      tsh   = shift;
    end else if (code >= 8'h1E && code <= 8'h27) begin
      txt   = digit_char(dig[3:0], shift);
      txt_v = !(shift && (dig[3:0] <= 4'd4 || dig[3:0] == 4'd6));
      tsh   = shift;
    end else begin
      unique case (code)
        8'h28, 8'h58: begin key_v = 1'b1; key = 8'd0; end
        8'h29:        begin key_v = 1'b1; key = 8'd1; end
        8'h2A, 8'h4C: begin key_v = 1'b1; key = 8'd2; end
        8'h2B, 8'h4B: begin key_v = 1'b1; key = 8'd3; end
        8'h49:        begin key_v = 1'b1; key = 8'd4; end
        8'h4A:        begin key_v = 1'b1; key = 8'd5; end
        8'h4D:        begin key_v = 1'b1; key = 8'd6; end
        8'h3A:        begin key_v = 1'b1; key = 8'd7; end
        8'h3B:        begin key_v = 1'b1; key = 8'd8; end
        8'h3C:        begin key_v = 1'b1; key = 8'd9; end
        8'h3D:        begin key_v = 1'b1; key = 8'd10; end
        8'h3E:        begin key_v = 1'b1; key = 8'd11; end
        8'h4F:        begin key_v = 1'b1; key = 8'd12; end
        8'h50:        begin key_v = 1'b1; key = 8'd13; end
        8'h51:        begin key_v = 1'b1; key = 8'd14; end
        8'h52:        begin key_v = 1'b1; key = 8'd15; end
        8'h2C:        begin txt_v = 1'b1; txt = " "; tsh = shift; end
        8'h2E:        begin txt_v = 1'b1; txt = shift ? "+" : "="; tsh = shift; end
        8'h2D:        begin txt_v = !shift; txt = "-"; end
        8'h2F:        begin txt_v = !shift; txt = "["; end
        8'h30:        begin txt_v = !shift; txt = "]"; end
        8'h33:        begin txt_v = shift; txt = ":"; tsh = 1'b1; end
        8'h36:        begin txt_v = !shift; txt = ","; end
        8'h37:        begin txt_v = !shift; txt = "."; end
        8'h38:        begin txt_v = !shift; txt = "/"; end
        8'h54:        begin txt_v = 1'b1; txt = "/"; end
        8'h55:        begin txt_v = 1'b1; txt = "*"; end
        8'h56:        begin txt_v = 1'b1; txt = "-"; end
        8'h57:        begin txt_v = 1'b1; txt = "+"; end
        8'h59:        begin txt_v = 1'b1; txt = "1"; end
        8'h5A:        begin txt_v = 1'b1; txt = "2"; end
        8'h5B:        begin txt_v = 1'b1; txt = "3"; end
        8'h5C:        begin txt_v = 1'b1; txt = "4"; end
        8'h5D:        begin txt_v = 1'b1; txt = "5"; end
        8'h5E:        begin txt_v = 1'b1; txt = "6"; end
        8'h5F:        begin txt_v = 1'b1; txt = "7"; end
        8'h60:        begin txt_v = 1'b1; txt = "8"; end
        8'h61:        begin txt_v = 1'b1; txt = "9"; end
        8'h62:        begin txt_v = 1'b1; txt = "0"; end
        8'h63:        begin txt_v = 1'b1; txt = "."; end
        8'h67:        begin txt_v = 1'b1; txt = "="; end
        default:      begin key_v = 1'b0; end
      endcase
    end
    res.is_new  = (code != 8'd0) && !seen;
    res.is_caps = res.is_new && (code == CAPS_CODE);
    res.ok      = res.is_new && !res.is_caps && !unsup && (key_v || txt_v);
    res.kind    = key_v ? KIND_KEY : KIND_TEXT;
    res.val     = key_v ? key : txt;
    res.sh      = key_v ? 1'b0 : tsh;
  end

endmodule

[hdl/hkt_outbuf.sv]
// ----------------------------------------------------------------------------
// hkt_outbuf
// result buffer: drains translated transactions then the summary
// ----------------------------------------------------------------------------
module hkt_outbuf (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  hkt_pkg::item_t [hkt_pkg::KEY_SLOTS-1:0] items,
  input  logic [hkt_pkg::CNT_W-1:0]               cnt,
  input  hkt_pkg::summ_t                          summ,
  output logic                                    can_load,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_is_summary,
  output logic                                    out_input_kind,
  output logic [7:0]                              out_code_value,
  output logic                                    out_shift_flag,
  output logic                                    out_repeat_flag,
  output logic [1:0]                              out_report_status,
  output logic [2:0]                              out_emitted_count,
  output logic [2:0]                              out_unsupported_in_item,
  output logic [31:0]                             out_unsupported_total,
  output logic                                    out_last
);
  import hkt_pkg::*;

  item_t [KEY_SLOTS-1:0] items_r;
  summ_t                 summ_r;
  logic [CNT_W-1:0]      cnt_r, idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  at_sum;
  item_t                 cur;

  assign at_sum    = (idx_r == cnt_r);
  assign out_valid = busy_r;
  assign can_load  = !busy_r || (out_ready && at_sum);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (busy_r && out_ready) begin
      if (at_sum) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 1'b1;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (load) cnt_r <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= items;
      summ_r  <= summ;
    end
  end

  always_comb begin
    cur = '0;
    for (int k = 0; k < KEY_SLOTS; k++) begin
      if (idx_r == CNT_W'(k)) cur = items_r[k];
    end
    if (at_sum) cur = '0;
  end

  assign out_is_summary          = at_sum;
  assign out_input_kind          = cur.kind;
  assign out_code_value          = cur.val;
  assign out_shift_flag          = cur.sh;
  assign out_repeat_flag         = cur.rep;
  assign out_report_status       = at_sum ? summ_r.status : 2'd0;
  assign out_emitted_count       = at_sum ? summ_r.emitted : 3'd0;
  assign out_unsupported_in_item = at_sum ? summ_r.dropped : 3'd0;
  assign out_unsupported_total   = at_sum ? summ_r.total : 32'd0;
  assign out_last                = at_sum;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= cnt_r) else $error("index past count");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(KEY_SLOTS)) else $error("count too large");
  a_sum_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && at_sum) |-> summ_r.emitted == cnt_r) else $error("summary count mismatch");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load) else $error("load while busy");
`endif

endmodule

[hdl/hid_keyboard_report_translator.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_translator
// boot keyboard report to text/key translation with typematic repeat
// ----------------------------------------------------------------------------
// the first result is presented in the cycle after the input transaction is accepted
// throughput: an item gives emitted+1 results, one per cycle while out_ready is high; the next input
//   is taken in the cycle its predecessor's summary leaves the output buffer
// six translation lanes and the merge run in the accept cycle
// reset (synchronous, rst_n low): all key state cleared, delay 500, interval 100
module hid_keyboard_report_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_report_length,
  input  logic [7:0]  in_modifiers,
  input  logic [7:0]  in_key_code_0,
  input  logic [7:0]  in_key_code_1,
  input  logic [7:0]  in_key_code_2,
  input  logic [7:0]  in_key_code_3,
  input  logic [7:0]  in_key_code_4,
  input  logic [7:0]  in_key_code_5,
  input  logic [31:0] in_now_ms,
  input  logic [2:0]  in_out_space,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_summary,
  output logic        out_input_kind,
  output logic [7:0]  out_code_value,
  output logic        out_shift_flag,
  output logic        out_repeat_flag,
  output logic [1:0]  out_report_status,
  output logic [2:0]  out_emitted_count,
  output logic [2:0]  out_unsupported_in_item,
  output logic [31:0] out_unsupported_total,
  output logic        out_last
);
  import hkt_pkg::*;

  logic [15:0]                 repeat_delay_ms_r, repeat_interval_ms_r;
  logic [KEY_SLOTS-1:0][7:0]   prev_keys_r, codes;
  logic                        caps_r, caps_nxt;
  logic [7:0]                  rkey_r, rkey_nxt;
  logic                        rkind_r, rkind_nxt, rsh_r, rsh_nxt;
  logic [7:0]                  rcode_r, rcode_nxt;
  logic [31:0]                 nrt_r, nrt_nxt, total_r, total_nxt;
  logic [KEY_SLOTS:0]          caps_at;
  lane_res_t [KEY_SLOTS-1:0]   res;
  logic [KEY_SLOTS-1:0][CNT_W-1:0] pos;
  logic [KEY_SLOTS-1:0]        emit, drop;
  logic [CNT_W-1:0]            n_ok, n_emit, n_drop;
  item_t [KEY_SLOTS-1:0]       items;
  summ_t                       summ;
  logic                        can_load, accept, bad_len, roll, present, due, upd;
  logic [31:0]                 diff, arm_time;

  assign codes = {in_key_code_5, in_key_code_4, in_key_code_3,
                  in_key_code_2, in_key_code_1, in_key_code_0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_delay_ms_r    <= 16'd500;
      repeat_interval_ms_r <= 16'd100;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) repeat_delay_ms_r <= cfg_data;
      else repeat_interval_ms_r <= cfg_data;
    end
  end

  always_comb begin
    caps_at[0] = caps_r;
    for (int i = 0; i < KEY_SLOTS; i++) caps_at[i+1] = caps_at[i] ^ res[i].is_caps;
  end

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkt_lane u_lane (
      .code      (codes[g]),
      .mods      (in_modifiers),
      .caps_in   (caps_at[g]),
      .prev_keys (prev_keys_r),
      .res       (res[g])
    );
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = can_load;
  assign diff     = in_now_ms - nrt_r;
  assign due      = !diff[31];
  assign arm_time = in_now_ms + {16'd0, repeat_delay_ms_r};

  always_comb begin
    bad_len = (in_report_length != 8'(REPORT_BYTES));
    roll    = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (codes[i] >= 8'h01 && codes[i] <= 8'h03) roll = 1'b1;
    end
    n_ok   = '0;
    n_emit = '0;
    n_drop = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      pos[i]  = n_ok;
      emit[i] = res[i].ok && (n_ok < in_out_space);
      drop[i] = (res[i].is_new && !res[i].is_caps && !res[i].ok) ||
                (res[i].ok && !(n_ok < in_out_space));
      n_ok    = n_ok + CNT_W'(res[i].ok);
      n_emit  = n_emit + CNT_W'(emit[i]);
      n_drop  = n_drop + CNT_W'(drop[i]);
    end
    for (int k = 0; k < KEY_SLOTS; k++) begin
      items[k] = '0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (emit[j] && pos[j] == CNT_W'(k)) begin
          items[k].kind = res[j].kind;
          items[k].val  = res[j].val;
          items[k].sh   = res[j].sh;
        end
      end
    end

    caps_nxt  = caps_r;
    rkey_nxt  = rkey_r;
    rkind_nxt = rkind_r;
    rcode_nxt = rcode_r;
    rsh_nxt   = rsh_r;
    nrt_nxt   = nrt_r;
    total_nxt = total_r;
    summ      = '0;
    upd       = 1'b0;
    present   = 1'b0;

    if (in_func) begin
      if (rkey_r != 8'd0 && due && in_out_space != 3'd0) begin
        items[0]     = '{kind: rkind_r, val: rcode_r, sh: rsh_r, rep: 1'b1};
        nrt_nxt      = in_now_ms + {16'd0, repeat_interval_ms_r};
        summ.emitted = 3'd1;
        upd          = 1'b1;
      end
      summ.status = ST_OK;
    end else if (bad_len) begin
      summ.status = ST_BAD_LEN;
    end else if (roll) begin
      summ.status = ST_ROLLOVER;
    end else begin
      upd       = 1'b1;
      caps_nxt  = caps_at[KEY_SLOTS];
      total_nxt = total_r + {29'd0, n_drop};
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (res[i].is_caps) begin
          rkey_nxt = 8'd0;
        end else if (res[i].ok) begin
          rkey_nxt  = codes[i];
          rkind_nxt = res[i].kind;
          rcode_nxt = res[i].val;
          rsh_nxt   = res[i].sh;
          nrt_nxt   = arm_time;
        end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (codes[i] == rkey_nxt) present = 1'b1;
      end
      if (rkey_nxt != 8'd0 && !present) begin
        rkey_nxt = 8'd0;
        nrt_nxt  = 32'd0;
      end
      summ.status  = ST_OK;
      summ.emitted = n_emit;
      summ.dropped = n_drop;
    end
    summ.total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
      caps_r      <= 1'b0;
      rkey_r      <= 8'd0;
      rkind_r     <= 1'b0;
      rcode_r     <= 8'd0;
      rsh_r       <= 1'b0;
      nrt_r       <= 32'd0;
      total_r     <= 32'd0;
    end else if (accept && upd) begin
      if (!in_func) prev_keys_r <= codes;
      caps_r  <= caps_nxt;
      rkey_r  <= rkey_nxt;
      rkind_r <= rkind_nxt;
      rcode_r <= rcode_nxt;
      rsh_r   <= rsh_nxt;
      nrt_r   <= nrt_nxt;
      total_r <= total_nxt;
    end
  end

  hkt_outbuf u_outbuf (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .load                    (accept),
    .items                   (items),
    .cnt                     (summ.emitted),
    .summ                    (summ),
    .can_load                (can_load),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_is_summary          (out_is_summary),
    .out_input_kind          (out_input_kind),
    .out_code_value          (out_code_value),
    .out_shift_flag          (out_shift_flag),
    .out_repeat_flag         (out_repeat_flag),
    .out_report_status       (out_report_status),
    .out_emitted_count       (out_emitted_count),
    .out_unsupported_in_item (out_unsupported_in_item),
    .out_unsupported_total   (out_unsupported_total),
    .out_last                (out_last)
  );

`ifndef SYNTHESIS
  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> summ.emitted <= in_out_space) else $error("emitted beyond space");
  a_bad_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_func && bad_len) |=> $stable(prev_keys_r) && $stable(total_r))
    else $error("state changed on bad length");
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> total_r == $past(total_r) + {29'd0, $past(summ.dropped)})
    else $error("dropped total mismatch");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives boot keyboard reports and millisecond ticks into the translator and
// checks every result against a local translation and typematic repeat model
// ----------------------------------------------------------------------------
module testbench;
  import hkt_pkg::*;

  localparam int N_RANDOM = 440;
  localparam logic CFG_DELAY    = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;
  localparam logic FUNC_REPORT  = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  len;
    logic [7:0]  mods;
    logic [47:0] keys;
    logic [31:0] now;
    logic [2:0]  space;
  } kbd_txn_t;

  typedef struct packed {
    logic        is_summary;
    logic        kind;
    logic [7:0]  code;
    logic        sh;
    logic        rep;
    logic [1:0]  status;
    logic [2:0]  emitted;
    logic [2:0]  dropped;
    logic [31:0] total;
    logic        last;
  } kbd_res_t;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic in_func;
  logic [7:0] in_report_length, in_modifiers;
  logic [7:0] k0, k1, k2, k3, k4, k5;
  logic [31:0] in_now_ms;
  logic [2:0] in_out_space;
  logic o_sum, o_kind, o_sh, o_rep, o_last;
  logic [7:0] o_code;
  logic [1:0] o_status;
  logic [2:0] o_emit, o_drop;
  logic [31:0] o_total;

  hid_keyboard_report_translator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_report_length(in_report_length),
    .in_modifiers(in_modifiers), .in_key_code_0(k0), .in_key_code_1(k1),
    .in_key_code_2(k2), .in_key_code_3(k3), .in_key_code_4(k4),
    .in_key_code_5(k5), .in_now_ms(in_now_ms), .in_out_space(in_out_space),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_summary(o_sum),
    .out_input_kind(o_kind), .out_code_value(o_code), .out_shift_flag(o_sh),
    .out_repeat_flag(o_rep), .out_report_status(o_status),
    .out_emitted_count(o_emit), .out_unsupported_in_item(o_drop),
    .out_unsupported_total(o_total), .out_last(o_last)
  );

  // model state
  logic [7:0]  prev_keys [KEY_SLOTS];
  logic        caps_on;
  logic [7:0]  rpt_key;
  logic        rpt_kind;
  logic [7:0]  rpt_code;
  logic        rpt_sh;
  logic [31:0] rpt_due;
  logic [31:0] drop_total;
  logic [15:0] delay_ms, interval_ms;

  kbd_txn_t pending_txns[$];
  kbd_res_t expected_results[$];
  int errors, mismatches, n_items, n_results, n_repeats;
  logic busy_hold, quiet;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic logic translate_key(input logic [7:0] c, input logic [7:0] m,
      output logic kind, output logic [7:0] v, output logic s);
    logic shift;
    int key, txt;
    logic tsh;
    logic [7:0] d;
    shift = (m & SHIFT_MASK) != 0;
    key = -1; txt = -1; tsh = 1'b0;
    kind = KIND_KEY; v = 8'd0; s = 1'b0;
    if ((m & UNSUP_MASK) != 0) return 1'b0;
    if (c >= 8'h04 && c <= 8'h1D) begin
      txt = ((shift != caps_on) ? 8'h41 : 8'h61) + (c - 8'h04);
      tsh = shift;
    end else if (c >= 8'h1E && c <= 8'h27) begin
      if (shift) d = 8'("!@#$%^&*()" >> (8 * (9 - (c - 8'h1E))));
      else d = 8'("1234567890" >> (8 * (9 - (c - 8'h1E))));
      if (d == "!" || d == "@" || d == "#" || d == "$" || d == "%" || d == "&")
        return 1'b0;
      txt = d; tsh = shift;
    end else begin
      case (c)
        8'h28, 8'h58: key = 0;
        8'h29: key = 1;
        8'h2A, 8'h4C: key = 2;
        8'h2B, 8'h4B: key = 3;
        8'h49: key = 4;
        8'h4A: key = 5;
        8'h4D: key = 6;
        8'h3A: key = 7;
        8'h3B: key = 8;
        8'h3C: key = 9;
        8'h3D: key = 10;
        8'h3E: key = 11;
        8'h4F: key = 12;
        8'h50: key = 13;
        8'h51: key = 14;
        8'h52: key = 15;
        8'h2C: begin txt = " "; tsh = shift; end
        8'h2E: begin txt = shift ? "+" : "="; tsh = shift; end
        8'h2D: if (!shift) txt = "-";
        8'h2F: if (!shift) txt = "[";
        8'h30: if (!shift) txt = "]";
        8'h33: if (shift) begin txt = ":"; tsh = 1'b1; end
        8'h36: if (!shift) txt = ",";
        8'h37: if (!shift) txt = ".";
        8'h38: if (!shift) txt = "/";
        8'h54: txt = "/";
        8'h55: txt = "*";
        8'h56: txt = "-";
        8'h57: txt = "+";
        8'h59: txt = "1";
        8'h5A: txt = "2";
        8'h5B: txt = "3";
        8'h5C: txt = "4";
        8'h5D: txt = "5";
        8'h5E: txt = "6";
        8'h5F: txt = "7";
        8'h60: txt = "8";
        8'h61: txt = "9";
        8'h62: txt = "0";
        8'h63: txt = ".";
        8'h67: txt = "=";
        default: ;
      endcase
    end
    if (key >= 0) begin
      kind = KIND_KEY; v = 8'(key); s = 1'b0; return 1'b1;
    end
    if (txt >= 0) begin
      kind = KIND_TEXT; v = 8'(txt); s = tsh; return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic kbd_res_t make_item(logic kind, logic [7:0] v, logic s, logic r);
    kbd_res_t x;
    x = '0;
    x.kind = kind; x.code = v; x.sh = s; x.rep = r;
    return x;
  endfunction

  function automatic void push_summary(logic [1:0] st, logic [2:0] em, logic [2:0] dr);
    kbd_res_t x;
    x = '0;
    x.is_summary = 1'b1; x.status = st; x.emitted = em; x.dropped = dr;
    x.total = drop_total; x.last = 1'b1;
    expected_results.push_back(x);
  endfunction

  function automatic void predict_translation(kbd_txn_t t);
    logic [7:0] c [KEY_SLOTS];
    logic [2:0] em, dr;
    logic kind, s, ok, held;
    logic [7:0] v;
    for (int i = 0; i < KEY_SLOTS; i++) c[i] = t.keys[8 * i +: 8];
    em = 0; dr = 0;
    if (t.func == FUNC_TICK) begin
      if (rpt_key != 0 && (t.now - rpt_due) < 32'h8000_0000 && t.space != 0) begin
        expected_results.push_back(make_item(rpt_kind, rpt_code, rpt_sh, 1'b1));
        rpt_due = t.now + interval_ms;
        push_summary(ST_OK, 3'd1, 3'd0);
      end else begin
        push_summary(ST_OK, 3'd0, 3'd0);
      end
      return;
    end
    if (t.len != REPORT_BYTES) begin
      push_summary(ST_BAD_LEN, 3'd0, 3'd0);
      return;
    end
    for (int i = 0; i < KEY_SLOTS; i++)
      if (c[i] >= 8'h01 && c[i] <= 8'h03) begin
        push_summary(ST_ROLLOVER, 3'd0, 3'd0);
        return;
      end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) if (prev_keys[j] == c[i]) held = 1'b1;
      if (c[i] == 0 || held) continue;
      if (c[i] == CAPS_CODE) begin
        caps_on = !caps_on; rpt_key = 0;
        continue;
      end
      ok = translate_key(c[i], t.mods, kind, v, s);
      if (!ok) begin
        drop_total++; dr++;
        continue;
      end
      if (em < t.space) begin
        expected_results.push_back(make_item(kind, v, s, 1'b0));
        em++;
      end else begin
        drop_total++; dr++;
      end
      rpt_key = c[i]; rpt_kind = kind; rpt_code = v; rpt_sh = s;
      rpt_due = t.now + delay_ms;
    end
    if (rpt_key != 0) begin
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) if (c[j] == rpt_key) held = 1'b1;
      if (!held) begin
        rpt_key = 0; rpt_due = 0;
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) prev_keys[i] = c[i];
    push_summary(ST_OK, em, dr);
  endfunction

  function automatic kbd_txn_t report_txn(logic [7:0] m, logic [47:0] keys,
      logic [31:0] now, logic [2:0] space);
    kbd_txn_t t;
    t.func = FUNC_REPORT; t.len = REPORT_BYTES; t.mods = m; t.keys = keys;
    t.now = now; t.space = space;
    return t;
  endfunction

  function automatic kbd_txn_t tick_txn(logic [31:0] now, logic [2:0] space);
    kbd_txn_t t;
    t = kbd_txn_t'({$urandom, $urandom, $urandom});
    t.func = FUNC_TICK; t.now = now; t.space = space;
    return t;
  endfunction

  function automatic logic [7:0] rand_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 45) return 8'($urandom_range(8'h04, 8'h27));
    if (r < 75) return 8'($urandom_range(8'h28, 8'h67));
    if (r < 80) return CAPS_CODE;
    if (r < 83) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_txns.size() != 0 && !busy_hold && (quiet || $urandom_range(0, 99) >= 7))
      begin
        kbd_txn_t t;
        t = pending_txns.pop_front();
        predict_translation(t);
        n_items++;
        in_valid <= 1'b1;
        in_func <= t.func; in_report_length <= t.len; in_modifiers <= t.mods;
        {k5, k4, k3, k2, k1, k0} <= t.keys;
        in_now_ms <= t.now; in_out_space <= t.space;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        kbd_res_t a, e;
        a = {o_sum, o_kind, o_code, o_sh, o_rep, o_status, o_emit, o_drop, o_total,
             o_last};
        n_results++;
        if (o_rep) n_repeats++;
        if (expected_results.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected transaction %h", a);
        end else begin
          e = expected_results.pop_front();
          if (a !== e) begin
            errors++;
            if (mismatches++ < 10) $display("mismatch: expected %h actual %h", e, a);
          end
        end
      end
      out_ready <= quiet || $urandom_range(0, 99) >= 7;
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DELAY) delay_ms = val;
    else interval_ms = val;
  endtask

  task automatic drain();
    while (pending_txns.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    kbd_txn_t t;
    logic [31:0] now;
    logic [15:0] dsel [4] = '{16'd1, 16'd65535, 16'd30, 16'd500};
    logic [15:0] isel [4] = '{16'd65535, 16'd1, 16'd10, 16'd100};
    errors = 0; mismatches = 0; n_items = 0; n_results = 0; n_repeats = 0;
    busy_hold = 1'b0; quiet = 1'b0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = CFG_DELAY; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0; in_func = 1'b0; in_report_length = '0;
    in_modifiers = '0; {k5, k4, k3, k2, k1, k0} = '0; in_now_ms = '0;
    in_out_space = '0;
    for (int i = 0; i < KEY_SLOTS; i++) prev_keys[i] = '0;
    caps_on = 0; rpt_key = 0; rpt_kind = 0; rpt_code = 0; rpt_sh = 0;
    rpt_due = 0; drop_total = 0; delay_ms = 500; interval_ms = 100;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_txns.push_back(report_txn(8'h00, {8'h05, 8'h06, 8'h1E, 8'h1F, 8'h27, 8'h04},
                                      32'd0, 3'd6));
    pending_txns.push_back(tick_txn(32'd499, 3'd6));
    pending_txns.push_back(tick_txn(32'd500, 3'd6));
    pending_txns.push_back(tick_txn(32'd600, 3'd0));
    pending_txns.push_back(report_txn(8'h22, {8'h2C, 8'h1F, 8'h1E, 8'h33, 8'h2D, 8'h2E},
                                      32'd700, 3'd6));
    pending_txns.push_back(report_txn(8'h02, {8'h00, 8'h00, 8'h00, 8'h39, 8'h1D, 8'h04},
                                      32'd710, 3'd6));
    pending_txns.push_back(report_txn(8'hFF, {8'h28, 8'h29, 8'h2A, 8'h2B, 8'h49, 8'h4A},
                                      32'd720, 3'd6));
    pending_txns.push_back(report_txn(8'h00, {8'h4D, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h3A},
                                      32'd730, 3'd2));
    pending_txns.push_back(report_txn(8'h00, {8'h67, 8'h63, 8'h62, 8'h54, 8'h54, 8'hFF},
                                      32'd740, 3'd6));
    pending_txns.push_back(report_txn(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04},
                                      32'd750, 3'd6));
    t = report_txn(8'h00, 48'h0, 32'd760, 3'd6); t.len = 8'd255;
    pending_txns.push_back(t);
    t.len = 8'd0; pending_txns.push_back(t);
    pending_txns.push_back(report_txn(8'h00, 48'h0, 32'hFFFF_FFF0, 3'd7));
    pending_txns.push_back(report_txn(8'h00, {40'h0, 8'h39}, 32'hFFFF_FFFF, 3'd6));
    pending_txns.push_back(report_txn(8'h00, {40'h0, 8'h04}, 32'hFFFF_FFFF, 3'd6));
    pending_txns.push_back(tick_txn(32'h0000_0300, 3'd1));
    pending_txns.push_back(tick_txn(32'h8000_0000, 3'd1));
    drain();

    // random phases over register settings
    now = 32'd1000;
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_DELAY, dsel[p]);
      write_reg(CFG_INTERVAL, isel[p]);
      quiet = (p == 2);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        int r;
        logic [47:0] keys;
        r = $urandom_range(0, 99);
        now += $urandom_range(0, (p == 1) ? 3 : 60);
        if ($urandom_range(0, 49) == 0) now = $urandom;
        if (r < 35) begin
          pending_txns.push_back(tick_txn(now, 3'($urandom_range(0, 7))));
        end else begin
          for (int i = 0; i < KEY_SLOTS; i++)
            keys[8 * i +: 8] = ($urandom_range(0, 2) == 0) ? 8'h00 : rand_code();
          t = report_txn(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                         ($urandom_range(0, 1) ? 8'h22 : 8'h00),
                         keys, now, 3'($urandom_range(0, 7)));
          if (r < 40) t.len = 8'($urandom_range(0, 255));
          pending_txns.push_back(t);
        end
      end
      if (p == 1) begin
        while (pending_txns.size() > 40) @(posedge clk);
        busy_hold = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        busy_hold = 1'b0;
      end
      drain();
    end

    $display("covered %0d items, %0d results, %0d typematic repeats, dropped total %0d",
             n_items, n_results, n_repeats, drop_total);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
